/* hw/rtl/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// HSL adjust package
// Shared types, constants and the reciprocal table of the HSL adjust pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAdjustMode = 2'd0,
    CfgDelta      = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    AdjSat = 1'b0,
    AdjLit = 1'b1
  } adj_mode_e;

  typedef enum logic [1:0] {
    SegUp   = 2'd0,
    SegHigh = 2'd1,
    SegDown = 2'd2,
    SegLow  = 2'd3
  } seg_e;

  // Multipliers for exact floor division by constants.
  localparam logic [24:0] M255 = 25'd16843010;  // ceil(2^32 / 255)
  localparam logic [24:0] M100 = 25'd21474837;  // ceil(2^31 / 100)
  localparam logic [19:0] M6   = 20'd699051;    // ceil(2^22 / 6)

  typedef logic [27:0] recip_tab_t [256];

  // Entry d holds floor(2^27 / d), built by long division at elaboration.
  function automatic recip_tab_t recip_table();
    recip_tab_t tab;
    logic [28:0] rem;
    logic [27:0] quo;
    logic [28:0] dividend;
    tab[0] = '0;
    for (int d = 1; d < 256; d++) begin
      rem      = '0;
      quo      = '0;
      dividend = 29'd1 << 27;
      for (int b = 28; b >= 0; b--) begin
        rem = {rem[27:0], dividend[b]};
        if (rem >= 29'(d)) begin
          rem = rem - 29'(d);
          if (b < 28) quo[b] = 1'b1;
        end
      end
      tab[d] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RecipTab = recip_table();

  typedef struct packed {
    logic [16:0] sat;
    logic [18:0] hue6;
    logic [16:0] lit;
  } fwd_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] lit;
  } adj_t;

endpackage

/* hw/rtl/hsl_if.sv */
// ----------------------------------------------------------------------------
// HSL adjust pixel channels
// Valid/ready channels that carry one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface hsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface hsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* hw/rtl/hsl_fwd.sv */
// ----------------------------------------------------------------------------
// HSL forward conversion
// Three stages that turn an RGB pixel into saturation, lightness and six
// times the hue, using reciprocal multiplication with a remainder fix-up.
// ----------------------------------------------------------------------------
module hsl_fwd (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [7:0]   red_i,
  input  logic [7:0]   green_i,
  input  logic [7:0]   blue_i,
  output logic         valid_o,
  input  logic         ready_i,
  output hsl_pkg::fwd_t res_o
);
  import hsl_pkg::*;

  logic [2:0] v_q;
  logic [2:0] en;

  logic [7:0]  mx, mn, dm, den;
  logic [8:0]  sum;
  logic [10:0] num, dm11, r11, g11, b11;

  logic [7:0]  dm1_q, den1_q;
  logic [8:0]  sum1_q;
  logic [10:0] num1_q;

  logic [27:0] rden, rdm;
  logic [51:0] ps;
  logic [54:0] ph;
  logic [48:0] pl;

  logic [16:0] qs2_q, lit2_q;
  logic [18:0] qy2_q;
  logic [7:0]  dm2_q, den2_q;
  logic [10:0] num2_q;

  logic [24:0] cs;
  logic [26:0] cy;
  logic [16:0] sat_d;
  logic [18:0] hue6_d;

  fwd_t res_q;

  always_comb begin
    en[2] = !v_q[2] || ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[2];
  assign res_o   = res_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dm   = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    den  = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    dm11 = {3'b0, dm};
    r11  = {3'b0, red_i};
    g11  = {3'b0, green_i};
    b11  = {3'b0, blue_i};
    if (mx == red_i) begin
      num = (green_i >= blue_i) ? g11 - b11
                                : (dm11 << 2) + (dm11 << 1) + g11 - b11;
    end else if (mx == green_i) begin
      num = (dm11 << 1) + b11 - r11;
    end else begin
      num = (dm11 << 2) + r11 - g11;
    end
  end

  always_comb begin
    rden = RecipTab[den1_q];
    rdm  = RecipTab[dm1_q];
    ps   = 52'({dm1_q, 16'b0}) * 52'(rden);
    ph   = 55'({num1_q, 16'b0}) * 55'(rdm);
    pl   = 49'({sum1_q, 15'b0}) * 49'(M255);
  end

  always_comb begin
    cs = 25'({dm2_q, 16'b0}) - 25'(qs2_q) * 25'(den2_q);
    cy = 27'({num2_q, 16'b0}) - 27'(qy2_q) * 27'(dm2_q);
    if (dm2_q == 8'd0) begin
      sat_d  = '0;
      hue6_d = '0;
    end else begin
      sat_d  = (cs >= 25'(den2_q)) ? qs2_q + 17'd1 : qs2_q;
      hue6_d = (cy >= 27'(dm2_q)) ? qy2_q + 19'd1 : qy2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dm1_q  <= dm;
      den1_q <= den;
      sum1_q <= sum;
      num1_q <= num;
    end
    if (en[1]) begin
      qs2_q  <= ps[43:27];
      qy2_q  <= ph[45:27];
      lit2_q <= pl[48:32];
      dm2_q  <= dm1_q;
      den2_q <= den1_q;
      num2_q <= num1_q;
    end
    if (en[2]) begin
      res_q.sat  <= sat_d;
      res_q.hue6 <= hue6_d;
      res_q.lit  <= lit2_q;
    end
  end

endmodule

/* hw/rtl/hsl_adj.sv */
// ----------------------------------------------------------------------------
// HSL adjust stage
// Two stages that finish the hue and add the delta to saturation or lightness,
// clamping the result.
// ----------------------------------------------------------------------------
module hsl_adj (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsl_pkg::adj_mode_e mode_i,
  input  logic signed [7:0]  delta_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  hsl_pkg::fwd_t      fwd_i,
  output logic               valid_o,
  input  logic               ready_i,
  output hsl_pkg::adj_t      res_o
);
  import hsl_pkg::*;

  logic [1:0] v_q;
  logic [1:0] en;

  logic [38:0]        py;
  logic [16:0]        v;
  logic [23:0]        v100;
  logic signed [25:0] t;

  logic [15:0] hue4_q;
  logic [23:0] tpos4_q;
  logic [16:0] oth4_q;
  adj_mode_e   mode4_q;

  logic [48:0] pa;
  logic [17:0] a;
  logic [16:0] ac;

  adj_t res_q;

  always_comb begin
    en[1] = !v_q[1] || ready_i;
    en[0] = !v_q[0] || en[1];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[1];
  assign res_o   = res_q;

  always_comb begin
    py   = 39'(fwd_i.hue6) * 39'(M6);
    v    = (mode_i == AdjLit) ? fwd_i.lit : fwd_i.sat;
    v100 = 24'(v) * 24'd100;
    t    = $signed({2'b0, v100}) + $signed({{2{delta_i[7]}}, delta_i, 16'b0});
  end

  always_comb begin
    pa = 49'(tpos4_q) * 49'(M100);
    a  = pa[48:31];
    ac = (a > 18'd65536) ? 17'd65536 : a[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hue4_q  <= py[37:22];
      tpos4_q <= t[25] ? 24'd0 : t[23:0];
      oth4_q  <= (mode_i == AdjLit) ? fwd_i.sat : fwd_i.lit;
      mode4_q <= mode_i;
    end
    if (en[1]) begin
      res_q.hue <= hue4_q;
      res_q.sat <= (mode4_q == AdjLit) ? oth4_q : ac;
      res_q.lit <= (mode4_q == AdjLit) ? ac : oth4_q;
    end
  end

endmodule

/* hw/rtl/hsl_back.sv */
// ----------------------------------------------------------------------------
// HSL back conversion
// Four stages that turn hue, saturation and lightness back into RGB; the last
// stage is the output register.
// ----------------------------------------------------------------------------
module hsl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsl_pkg::adj_t adj_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o
);
  import hsl_pkg::*;

  localparam logic [19:0] Turn6 = 20'd393216;

  logic [3:0] v_q;
  logic [3:0] en;

  logic [16:0] m;
  logic [33:0] pm;
  logic [18:0] h6;
  logic [19:0] ofs [3];
  logic [19:0] tw  [3];
  seg_e        seg  [3];
  logic [16:0] frac [3];

  logic [31:0] p6_q;
  logic [16:0] lit6_q;
  seg_e        seg6_q  [3];
  logic [16:0] frac6_q [3];

  logic [32:0] base, pv, qv;
  logic [32:0] pa [3];
  logic [32:0] pb [3];

  logic [32:0] p7_q, q7_q;
  logic [32:0] a7_q [3];
  logic [32:0] b7_q [3];
  seg_e        seg7_q [3];

  logic [33:0] inc [3];
  logic [32:0] f   [3];
  logic [32:0] f8_q [3];

  logic [40:0] c [3];
  logic [7:0]  out_q [3];

  always_comb begin
    en[3] = !v_q[3] || ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[3];
  assign red_o   = out_q[0];
  assign green_o = out_q[1];
  assign blue_o  = out_q[2];

  always_comb begin
    m      = (adj_i.lit[16:15] == 2'b00) ? adj_i.lit : 17'd65536 - adj_i.lit;
    pm     = 34'(adj_i.sat) * 34'(m);
    h6     = (19'(adj_i.hue) << 2) + (19'(adj_i.hue) << 1);
    ofs[0] = 20'd131072;
    ofs[1] = 20'd0;
    ofs[2] = 20'd262144;
    for (int k = 0; k < 3; k++) begin
      tw[k] = {1'b0, h6} + ofs[k];
      if (tw[k] >= Turn6) tw[k] = tw[k] - Turn6;
      if (tw[k] < 20'd65536) begin
        seg[k]  = SegUp;
        frac[k] = tw[k][16:0];
      end else if (tw[k] < 20'd196608) begin
        seg[k]  = SegHigh;
        frac[k] = '0;
      end else if (tw[k] < 20'd262144) begin
        seg[k]  = SegDown;
        frac[k] = 17'(20'd262144 - tw[k]);
      end else begin
        seg[k]  = SegLow;
        frac[k] = '0;
      end
    end
  end

  always_comb begin
    base = {lit6_q, 16'b0};
    pv   = base - 33'(p6_q);
    qv   = base + 33'(p6_q);
    for (int k = 0; k < 3; k++) begin
      pa[k] = 33'(p6_q[31:16]) * 33'(frac6_q[k]);
      pb[k] = 33'(p6_q[15:0]) * 33'(frac6_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inc[k] = 34'({a7_q[k], 1'b0}) + 34'(b7_q[k][32:15]);
      unique case (seg7_q[k])
        SegUp, SegDown: f[k] = p7_q + inc[k][32:0];
        SegHigh:        f[k] = q7_q;
        SegLow:         f[k] = p7_q;
        default:        f[k] = p7_q;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = {f8_q[k], 8'b0} - 41'(f8_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p6_q   <= pm[31:0];
      lit6_q <= adj_i.lit;
      for (int k = 0; k < 3; k++) begin
        seg6_q[k]  <= seg[k];
        frac6_q[k] <= frac[k];
      end
    end
    if (en[1]) begin
      p7_q <= pv;
      q7_q <= qv;
      for (int k = 0; k < 3; k++) begin
        a7_q[k]   <= pa[k];
        b7_q[k]   <= pb[k];
        seg7_q[k] <= seg6_q[k];
      end
    end
    if (en[2]) begin
      for (int k = 0; k < 3; k++) f8_q[k] <= f[k];
    end
    if (en[3]) begin
      for (int k = 0; k < 3; k++) out_q[k] <= c[k][39:32];
    end
  end

endmodule

/* hw/rtl/hsl_saturation_lightness_adjust_unit.sv */
// ----------------------------------------------------------------------------
// HSL saturation/lightness adjust unit
// Converts each RGB pixel to HSL, shifts saturation or lightness by a signed
// delta in hundredths, and converts the pixel back to RGB.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the output is not stalled and
// returns the pixels in order, through three stages of RGB to HSL conversion,
// two of adjustment and four of HSL to RGB conversion, the last being the
// output register. Every stage holds its beat while the one after it is full,
// so the input keeps accepting pixels until the pipeline is full behind a
// stalled output. Configuration must be written through the plain write port
// only while no pixel is in flight; the unit itself does not enforce this.
module hsl_saturation_lightness_adjust_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hsl_in_if.sink                        pix_in,
  hsl_out_if.source                     pix_out,
  input  logic                          cfg_we_i,
  input  logic [hsl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hsl_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import hsl_pkg::*;

  adj_mode_e         mode_q;
  logic signed [7:0] delta_q;

  logic  fwd_valid, fwd_ready, adj_valid, adj_ready;
  fwd_t  fwd_res;
  adj_t  adj_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= AdjSat;
      delta_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAdjustMode: mode_q  <= adj_mode_e'(cfg_wdata_i[0]);
        CfgDelta:      delta_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  hsl_fwd u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_in.valid),
    .ready_o (pix_in.ready),
    .red_i   (pix_in.in_red),
    .green_i (pix_in.in_green),
    .blue_i  (pix_in.in_blue),
    .valid_o (fwd_valid),
    .ready_i (fwd_ready),
    .res_o   (fwd_res)
  );

  hsl_adj u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .delta_i (delta_q),
    .valid_i (fwd_valid),
    .ready_o (fwd_ready),
    .fwd_i   (fwd_res),
    .valid_o (adj_valid),
    .ready_i (adj_ready),
    .res_o   (adj_res)
  );

  hsl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (adj_valid),
    .ready_o (adj_ready),
    .adj_i   (adj_res),
    .valid_o (pix_out.valid),
    .ready_i (pix_out.ready),
    .red_o   (pix_out.out_red),
    .green_o (pix_out.out_green),
    .blue_o  (pix_out.out_blue)
  );

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_out.ready |-> pix_in.ready)
    else $error("Input stalled while the output side is ready.");

  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i != CfgAdjustMode && cfg_idx_i != CfgDelta)
    |=> ($stable(mode_q) && $stable(delta_q)))
    else $error("Write beyond the register list changed a register.");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CfgAdjustMode) |=> (mode_q == $past(cfg_wdata_i[0])))
    else $error("Mode register did not take the written value.");

endmodule
